@@ rtl/msmf_pkg.sv @@
// shared types and constants for the midi event to smf track byte encoder
// no dependencies; imported by msmf_ctrl, msmf_dp and the top level
`default_nettype none

package msmf_pkg;

  // field widths
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned TRACK_W = 4;
  localparam int unsigned SEL_W   = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned VLQ_W   = 28;
  localparam int unsigned GRP_W   = 7;

  // opcodes carried on the input tuser
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_START = 1'b1;

  // register word select (paddr bit 2)
  localparam logic REG_SEL_TRACK = 1'b0;

  // constants of the encoding
  localparam logic [SEL_W-1:0]  TRACK_NONE     = 5'd16;
  localparam logic [BYTE_W-1:0] REALTIME_FIRST = 8'hf8;
  localparam logic [VLQ_W-1:0]  DELTA_MAX      = 28'hfffffff;

  // message types from the status high nibble
  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
  localparam logic [3:0] KIND_POLY_AT   = 4'ha;
  localparam logic [3:0] KIND_CTRL      = 4'hb;
  localparam logic [3:0] KIND_PROGRAM   = 4'hc;
  localparam logic [3:0] KIND_CHAN_AT   = 4'hd;
  localparam logic [3:0] KIND_PITCH     = 4'he;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DELTA,
    ST_STATUS,
    ST_DATA1,
    ST_DATA2
  } msmf_state_t;

  // source of an emitted byte
  typedef enum logic [1:0] {
    SRC_DELTA,
    SRC_STATUS,
    SRC_DATA1,
    SRC_DATA2
  } msmf_src_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      capture;
    logic      eval;
    logic      emit;
    msmf_src_t src;
    logic      last;
  } msmf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic start;
    logic drop;
    logic two_data;
    logic last_group;
    logic out_free;
  } msmf_stat_t;

endpackage

`default_nettype wire

@@ rtl/midi_event_to_smf_track_bytes.sv @@
// Encodes timestamped MIDI channel events into Standard MIDI File track body
// bytes: a variable-length tick delta (1 to 4 bytes), the status byte, and one
// or two data bytes, each with the running track byte count. Realtime status,
// events of other tracks and non-channel types are dropped; tuser = 1 starts a
// new track (clears last tick and count). One event is handled at a time: the
// input is taken in idle, evaluated in the next cycle (subtract, saturate,
// group split), then one byte leaves per cycle through the output register
// while the output side can take it. A dropped or start transaction goes back
// to idle straight from evaluation. selected_track resets to 16 (no track).
// depends on msmf_pkg, msmf_ctrl, msmf_dp
`default_nettype none

module midi_event_to_smf_track_bytes
  import msmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // event_tick[31:0], track_number[35:32],
                                      // status_byte[43:36], data_one[51:44],
                                      // data_two[59:52], zero[63:60]
  input  wire logic        in_tuser,  // opcode
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // out_byte[7:0], track_byte_count[39:8]
  output logic             out_tlast, // last_of_event
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  msmf_cmd_t           cmd;
  msmf_stat_t          stat;
  logic                sel_we;
  logic [SEL_W-1:0]    sel_track;
  logic [BYTE_W-1:0]   out_byte;
  logic [COUNT_W-1:0]  out_count;

  // register access
  assign cfg_pready = 1'b1;
  assign sel_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_SEL_TRACK);
  assign cfg_prdata = (cfg_paddr[2] == REG_SEL_TRACK) ?
                      {{(32-SEL_W){1'b0}}, sel_track} : 32'd0;

  msmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msmf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_tuser),
    .in_tick    (in_tdata[31:0]),
    .in_track   (in_tdata[35:32]),
    .in_status  (in_tdata[43:36]),
    .in_data1   (in_tdata[51:44]),
    .in_data2   (in_tdata[59:52]),
    .sel_we     (sel_we),
    .sel_wdata  (cfg_pwdata[SEL_W-1:0]),
    .sel_track  (sel_track),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_byte   (out_byte),
    .out_last   (out_tlast),
    .out_count  (out_count)
  );

  assign out_tdata = {out_count, out_byte};

endmodule

`default_nettype wire

@@ rtl/msmf_ctrl.sv @@
// controller state machine for the smf track byte encoder
// depends on msmf_pkg; drives msmf_dp through command and status structs
`default_nettype none

module msmf_ctrl
  import msmf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire msmf_stat_t stat,
  output msmf_cmd_t       cmd
);

  msmf_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.start || stat.drop) state_nxt = ST_IDLE;
        else                         state_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        if (stat.out_free && stat.last_group) state_nxt = ST_STATUS;
      end
      ST_STATUS: begin
        if (stat.out_free) state_nxt = ST_DATA1;
      end
      ST_DATA1: begin
        if (stat.out_free) state_nxt = stat.two_data ? ST_DATA2 : ST_IDLE;
      end
      ST_DATA2: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.eval    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.src     = SRC_DELTA;
    cmd.last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_DELTA: begin
        cmd.emit = stat.out_free;
        cmd.src  = SRC_DELTA;
      end
      ST_STATUS: begin
        cmd.emit = stat.out_free;
        cmd.src  = SRC_STATUS;
      end
      ST_DATA1: begin
        cmd.emit = stat.out_free;
        cmd.src  = SRC_DATA1;
        cmd.last = !stat.two_data;
      end
      ST_DATA2: begin
        cmd.emit = stat.out_free;
        cmd.src  = SRC_DATA2;
        cmd.last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // an event reaching the status byte always came through the delta bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STATUS) && !$past(state_r == ST_STATUS) |->
      $past(state_r == ST_DELTA))
    else $error("status phase entered without delta phase");

  // a byte is only emitted when the output register can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("emit while output register full");

  // no new transaction while an event is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !cmd.capture)
    else $error("capture outside idle");

endmodule

`default_nettype wire

@@ rtl/msmf_dp.sv @@
// datapath of the smf track byte encoder: input capture, filter, delta vlq,
// tick and byte count state, output register; depends on msmf_pkg
`default_nettype none

module msmf_dp
  import msmf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire msmf_cmd_t           cmd,
  output msmf_stat_t               stat,
  // captured input fields
  input  wire logic                in_opcode,
  input  wire logic [TICK_W-1:0]   in_tick,
  input  wire logic [TRACK_W-1:0]  in_track,
  input  wire logic [BYTE_W-1:0]   in_status,
  input  wire logic [BYTE_W-1:0]   in_data1,
  input  wire logic [BYTE_W-1:0]   in_data2,
  // configuration
  input  wire logic                sel_we,
  input  wire logic [SEL_W-1:0]    sel_wdata,
  output logic [SEL_W-1:0]         sel_track,
  // result register
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [BYTE_W-1:0]        out_byte,
  output logic                     out_last,
  output logic [COUNT_W-1:0]       out_count
);

  logic                opcode_r;
  logic [TICK_W-1:0]   tick_r;
  logic [TRACK_W-1:0]  track_r;
  logic [BYTE_W-1:0]   status_r, data1_r, data2_r;
  logic [SEL_W-1:0]    sel_r;
  logic [TICK_W-1:0]   last_tick_r;
  logic [COUNT_W-1:0]  count_r;
  logic [VLQ_W-1:0]    vlq_r;
  logic [2:0]          grp_left_r;
  logic                two_data_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [TICK_W-1:0]   diff;
  logic [VLQ_W-1:0]    delta_sat;
  logic [2:0]          ngroups;
  logic [VLQ_W-1:0]    vlq_load;
  logic                kind_ok, kind_two;
  logic                drop;
  logic [BYTE_W-1:0]   emit_byte;
  logic [COUNT_W-1:0]  count_inc;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r <= in_opcode;
      tick_r   <= in_tick;
      track_r  <= in_track;
      status_r <= in_status;
      data1_r  <= in_data1;
      data2_r  <= in_data2;
    end
  end

  // selected track register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= TRACK_NONE;
    end else if (sel_we) begin
      sel_r <= sel_wdata;
    end
  end

  // message type decode
  always_comb begin
    kind_ok  = 1'b0;
    kind_two = 1'b0;
    case (status_r[7:4])
      KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CTRL, KIND_PITCH: begin
        kind_ok  = 1'b1;
        kind_two = 1'b1;
      end
      KIND_PROGRAM, KIND_CHAN_AT: begin
        kind_ok = 1'b1;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  // filter: realtime, track mismatch, non channel type
  assign drop = (status_r >= REALTIME_FIRST) || ({1'b0, track_r} != sel_r) || !kind_ok;

  // delta, saturated, and left-aligned vlq groups
  assign diff      = tick_r - last_tick_r;
  assign delta_sat = (diff[TICK_W-1:VLQ_W] != '0) ? DELTA_MAX : diff[VLQ_W-1:0];

  always_comb begin
    if (delta_sat[27:21] != '0) begin
      ngroups  = 3'd4;
      vlq_load = delta_sat;
    end else if (delta_sat[20:14] != '0) begin
      ngroups  = 3'd3;
      vlq_load = {delta_sat[20:0], 7'b0};
    end else if (delta_sat[13:7] != '0) begin
      ngroups  = 3'd2;
      vlq_load = {delta_sat[13:0], 14'b0};
    end else begin
      ngroups  = 3'd1;
      vlq_load = {delta_sat[6:0], 21'b0};
    end
  end

  // byte select for the current emit
  always_comb begin
    case (cmd.src)
      SRC_DELTA:  emit_byte = {grp_left_r != 3'd1, vlq_r[VLQ_W-1 -: GRP_W]};
      SRC_STATUS: emit_byte = status_r;
      SRC_DATA1:  emit_byte = data1_r;
      SRC_DATA2:  emit_byte = data2_r;
      default:    emit_byte = status_r;
    endcase
  end

  assign count_inc = count_r + 1'b1;

  // tick and count state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
      count_r     <= '0;
    end else if (cmd.eval && opcode_r == OP_START) begin
      last_tick_r <= '0;
      count_r     <= '0;
    end else begin
      if (cmd.eval && !drop) last_tick_r <= tick_r;
      if (cmd.emit)          count_r     <= count_inc;
    end
  end

  // vlq shift register and group counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_left_r <= '0;
    end else if (cmd.eval) begin
      grp_left_r <= ngroups;
    end else if (cmd.emit && cmd.src == SRC_DELTA) begin
      grp_left_r <= grp_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      vlq_r      <= vlq_load;
      two_data_r <= kind_two;
    end else if (cmd.emit && cmd.src == SRC_DELTA) begin
      vlq_r <= {vlq_r[VLQ_W-GRP_W-1:0], {GRP_W{1'b0}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r  <= emit_byte;
      out_last_r  <= cmd.last;
      out_count_r <= count_inc;
    end
  end

  assign stat.start      = (opcode_r == OP_START);
  assign stat.drop       = drop;
  assign stat.two_data   = two_data_r;
  assign stat.last_group = (grp_left_r == 3'd1);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign sel_track = sel_r;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_count = out_count_r;

  // delta bytes are only taken while groups remain
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.src == SRC_DELTA |-> grp_left_r != 3'd0)
    else $error("delta byte emitted with no group left");

  // each emitted byte advances the count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> count_r == $past(count_inc))
    else $error("track byte count not advanced");

  // a pending result is not overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.emit)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/smf_track_checker.sv @@
// scoreboard for the midi event to smf track byte encoder: watches the input,
// result and register channels, predicts every track byte and compares
// depends on msmf_pkg for field widths, opcodes, message types and limits
`timescale 1ns / 1ps

module smf_track_checker
  import msmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          error_count,
  output int          pending_bytes
);

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [COUNT_W-1:0] count;
  } smf_byte_t;

  smf_byte_t          bytes_due[$];
  logic [SEL_W-1:0]   sel_track;
  logic [TICK_W-1:0]  last_tick;
  logic [COUNT_W-1:0] body_size;
  int                 fail_total = 0;
  int                 due_total = 0;

  assign error_count   = fail_total;
  assign pending_bytes = due_total;

  function void note_failure(input string msg);
    if (fail_total < 10) begin
      $display("%0t ns: track byte check: %s", $time, msg);
    end
    fail_total++;
  endfunction

  // every emitted byte bumps the running body size
  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
    smf_byte_t item;
    body_size  = body_size + 1;
    item.data  = value;
    item.last  = last;
    item.count = body_size;
    bytes_due.push_back(item);
  endtask

  // a start clears the track state; otherwise filter the event, then queue delta quantity, status and data bytes
  task automatic encode_event(input logic op, input logic [TICK_W-1:0] tick,
                              input logic [TRACK_W-1:0] trk,
                              input logic [BYTE_W-1:0] status,
                              input logic [BYTE_W-1:0] d1,
                              input logic [BYTE_W-1:0] d2);
    logic [TICK_W-1:0] delta;
    logic [GRP_W-1:0]  groups [4];
    int                ngroups;
    logic              two_data;
    if (op == OP_START) begin
      last_tick = '0;
      body_size = '0;
      return;
    end
    if (status >= REALTIME_FIRST) return;
    if ({1'b0, trk} != sel_track) return;
    case (status[7:4])
      KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CTRL, KIND_PITCH: begin
        two_data = 1'b1;
      end
      KIND_PROGRAM, KIND_CHAN_AT: begin
        two_data = 1'b0;
      end
      default: return;
    endcase

    // wrapped delta, clamped so the quantity fits in four groups
    delta = tick - last_tick;
    if (delta > {4'd0, DELTA_MAX}) delta = {4'd0, DELTA_MAX};
    ngroups = 0;
    do begin
      groups[ngroups] = delta[GRP_W-1:0];
      ngroups++;
      delta = delta >> GRP_W;
    end while (delta != 0 && ngroups < 4);

    // most significant group first, continuation bit on all but the last
    for (int i = ngroups - 1; i >= 0; i--) begin
      push_byte({(i > 0), groups[i]}, 1'b0);
    end
    push_byte(status, 1'b0);
    if (two_data) begin
      push_byte(d1, 1'b0);
      push_byte(d2, 1'b1);
    end else begin
      push_byte(d1, 1'b1);
    end
    last_tick = tick;
  endtask

  // compare one result transaction with the oldest queued byte
  task automatic check_byte(input logic [BYTE_W-1:0] data, input logic last,
                            input logic [COUNT_W-1:0] count);
    smf_byte_t want;
    if (bytes_due.size() == 0) begin
      note_failure($sformatf("unexpected byte %02h last %0b count %0d",
                             data, last, count));
    end else begin
      want = bytes_due.pop_front();
      if (want.data !== data || want.last !== last || want.count !== count) begin
        note_failure($sformatf(
          "expected byte %02h last %0b count %0d, got byte %02h last %0b count %0d",
          want.data, want.last, want.count, data, last, count));
      end
    end
  endtask

  // register writes, results, then new input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      sel_track = TRACK_NONE;
      last_tick = '0;
      body_size = '0;
      bytes_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_SEL_TRACK) begin
        sel_track = cfg_pwdata[SEL_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        check_byte(out_tdata[7:0], out_tlast, out_tdata[39:8]);
      end
      if (in_tvalid && in_tready) begin
        encode_event(in_tuser, in_tdata[31:0], in_tdata[35:32], in_tdata[43:36],
                     in_tdata[51:44], in_tdata[59:52]);
      end
    end
    due_total = bytes_due.size();
  end

endmodule

@@ tb/midi_event_to_smf_track_bytes_test.sv @@
// top of the encoder testbench: clock, reset, event stimulus, register writes
// and result-side back-pressure; checking is done in smf_track_checker
// depends on msmf_pkg, midi_event_to_smf_track_bytes and smf_track_checker
`timescale 1ns / 1ps

module midi_event_to_smf_track_bytes_test;
  import msmf_pkg::*;

  localparam logic [2:0] ADDR_TRACK = {REG_SEL_TRACK, 2'b00};
  localparam logic [2:0] ADDR_SPARE = {~REG_SEL_TRACK, 2'b00};
  localparam int         SETTLE_CYCLES = 12;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // event_tick[31:0], track_number[35:32], status_byte[43:36],
                           // data_one[51:44], data_two[59:52], zero[63:60]
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // out_byte[7:0], track_byte_count[39:8]
  logic        out_tlast;  // last_of_event
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int               error_count;
  int               pending_bytes;
  int               stall_pct = 0;
  int               sink_hold = 0;
  logic [SEL_W-1:0] sel_track = TRACK_NONE;
  logic [TICK_W-1:0] tick_cursor = '0;

  midi_event_to_smf_track_bytes u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  smf_track_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .error_count   (error_count),
    .pending_bytes (pending_bytes)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: long hold-off when requested, otherwise random stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one input transaction; returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [TICK_W-1:0] tick,
                           input logic [TRACK_W-1:0] trk,
                           input logic [BYTE_W-1:0] status,
                           input logic [BYTE_W-1:0] d1, input logic [BYTE_W-1:0] d2,
                           input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, d2, d1, status, trk, tick};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop offering and wait until every queued byte has left the block
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pending_bytes == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // upper bits of the write are junk the block must ignore
  task automatic select_track(input logic [SEL_W-1:0] value);
    drain();
    write_reg(ADDR_TRACK, {27'($urandom), value});
    sel_track = value;
  endtask

  // mostly well-formed events on the selected track, some noise
  task automatic send_random(input int idle_pct);
    int                pick;
    logic              op;
    logic [TICK_W-1:0] delta;
    logic [TRACK_W-1:0] trk;
    logic [3:0]        kind;
    logic [BYTE_W-1:0] status;
    case ($urandom_range(6))
      0: kind = KIND_NOTE_OFF;
      1: kind = KIND_NOTE_ON;
      2: kind = KIND_POLY_AT;
      3: kind = KIND_CTRL;
      4: kind = KIND_PROGRAM;
      5: kind = KIND_CHAN_AT;
      default: kind = KIND_PITCH;
    endcase
    // spread deltas over every quantity length, saturation and wrap
    case ($urandom_range(9))
      0: delta = '0;
      1, 2, 3: delta = $urandom_range(127);
      4, 5: delta = $urandom_range(16383, 128);
      6: delta = $urandom_range(32'h001f_ffff, 16384);
      7: delta = $urandom_range(32'h0fff_ffff, 32'h0020_0000);
      default: delta = $urandom;
    endcase
    op     = OP_EVENT;
    trk    = sel_track[TRACK_W-1:0];
    status = {kind, 4'($urandom_range(15))};
    pick   = $urandom_range(99);
    if (pick < 3) op = OP_START;
    else if (pick < 8) status = 8'($urandom_range(255, REALTIME_FIRST));
    else if (pick < 13) trk = 4'($urandom_range(15));
    else if (pick < 18) status = 8'($urandom_range(255));
    tick_cursor = (op == OP_START) ? '0 : tick_cursor + delta;
    send_item(op, tick_cursor, trk, status, 8'($urandom), 8'($urandom), idle_pct);
  endtask

  // main sequence
  initial begin
    logic [TICK_W-1:0] t;
    int                idle_pct;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = OP_EVENT;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no track selected after reset: everything is dropped
    send_item(OP_EVENT, 32'd10, 4'd0, {KIND_NOTE_ON, 4'h0}, 8'h3c, 8'h40, 0);
    send_item(OP_EVENT, 32'd11, 4'd15, {KIND_CTRL, 4'hf}, 8'h07, 8'h64, 0);

    // quantity lengths at their boundaries, every channel message type
    select_track(5'd5);
    t = '0;
    send_item(OP_EVENT, t, 4'd5, {KIND_NOTE_ON, 4'h5}, 8'h3c, 8'h7f, 0);
    t = t + 32'd127;
    send_item(OP_EVENT, t, 4'd5, {KIND_NOTE_OFF, 4'h5}, 8'h00, 8'h00, 0);
    t = t + 32'd128;
    send_item(OP_EVENT, t, 4'd5, {KIND_POLY_AT, 4'h5}, 8'h80, 8'hff, 0);
    t = t + 32'h3fff;
    send_item(OP_EVENT, t, 4'd5, {KIND_CTRL, 4'h5}, 8'h7f, 8'h80, 0);
    t = t + 32'h4000;
    send_item(OP_EVENT, t, 4'd5, {KIND_PROGRAM, 4'h5}, 8'hff, 8'h00, 0);
    t = t + 32'h001f_ffff;
    send_item(OP_EVENT, t, 4'd5, {KIND_CHAN_AT, 4'h5}, 8'h55, 8'haa, 0);
    t = t + 32'h0020_0000;
    send_item(OP_EVENT, t, 4'd5, {KIND_PITCH, 4'h5}, 8'hff, 8'hff, 0);
    t = t + 32'h0fff_ffff;
    send_item(OP_EVENT, t, 4'd5, {KIND_NOTE_ON, 4'h0}, 8'h01, 8'h02, 0);
    // delta just past the clamp, then a tick that goes backwards
    t = t + 32'h1000_0000;
    send_item(OP_EVENT, t, 4'd5, {KIND_NOTE_OFF, 4'hf}, 8'h10, 8'h20, 0);
    send_item(OP_EVENT, 32'd5, 4'd5, {KIND_NOTE_ON, 4'h5}, 8'h30, 8'h40, 0);
    // realtime, system and data-range status, wrong track: all dropped
    send_item(OP_EVENT, 32'd6, 4'd5, REALTIME_FIRST, 8'h00, 8'h00, 0);
    send_item(OP_EVENT, 32'd7, 4'd5, 8'hff, 8'h00, 8'h00, 0);
    send_item(OP_EVENT, 32'd8, 4'd5, 8'hf0, 8'h00, 8'h00, 0);
    send_item(OP_EVENT, 32'd9, 4'd5, 8'h00, 8'h00, 8'h00, 0);
    send_item(OP_EVENT, 32'd9, 4'd5, 8'h7f, 8'h00, 8'h00, 0);
    send_item(OP_EVENT, 32'd9, 4'd6, {KIND_NOTE_ON, 4'h5}, 8'h00, 8'h00, 0);
    // new track restarts the count and the tick base
    send_item(OP_START, 32'hffff_ffff, 4'd5, {KIND_NOTE_ON, 4'h5}, 8'h00, 8'h00, 0);
    send_item(OP_EVENT, 32'd300, 4'd5, {KIND_NOTE_ON, 4'h5}, 8'h40, 8'h50, 0);
    send_item(OP_EVENT, 32'hffff_ffff, 4'd5, {KIND_PROGRAM, 4'h5}, 8'h12, 8'h00, 0);
    send_item(OP_EVENT, 32'd0, 4'd5, {KIND_CTRL, 4'h5}, 8'h40, 8'h00, 0);

    // random phases, one idling pattern each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: select_track(5'd15);
        1: select_track(5'd0);
        2: begin
          select_track(5'($urandom_range(14, 1)));
          // the spare word must not disturb the track selection
          write_reg(ADDR_SPARE, 32'd3);
        end
        default: select_track(5'($urandom_range(14, 1)));
      endcase
      tick_cursor = $urandom;
      idle_pct    = (ph == 1) ? 64 : (ph == 3) ? 21 : 0;
      stall_pct   = (ph == 2) ? 64 : (ph == 3) ? 21 : 0;
      // result side holds off long enough for the block to back up
      if (ph == 2) sink_hold = 300;
      for (int n = 0; n < 48; n++) begin
        if (ph == 1 && n == 24) drain();
        send_random(idle_pct);
      end
    end

    // selections above the track range never match
    select_track(5'd31);
    for (int n = 0; n < 6; n++) send_random(21);
    select_track(5'd16);
    for (int n = 0; n < 4; n++) send_random(21);

    // final drain and verdict
    in_tvalid <= 1'b0;
    wait (pending_bytes == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
